// File: rtl/adfp_pkg.sv
// ----------------------------------------------------------------------------
// adfp_pkg
// Shared types, character codes and constant helpers for the ASCII decimal
// to fixed-point parser.
// ----------------------------------------------------------------------------
package adfp_pkg;

    localparam int FRAC_BITS_DEFAULT = 28;
    localparam int VALUE_W           = 64;
    localparam int INT_W             = 35;
    localparam int WEIGHT_STEPS      = 10;

    localparam logic [INT_W-1:0] INT_LIMIT = INT_W'(64'd2147483647);

    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_POINT = 8'h2E;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;
    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_CR    = 8'h0D;

    typedef enum logic [3:0] {
        PH_SKIP = 4'b0001,
        PH_INT  = 4'b0010,
        PH_FRAC = 4'b0100,
        PH_DONE = 4'b1000
    } phase_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
    endfunction

    function automatic logic is_blank(input logic [7:0] c);
        return (c == CHAR_SPACE) || ((c >= CHAR_TAB) && (c <= CHAR_CR));
    endfunction

    // Weight after k fraction digits: one in fixed point, cut to a tenth k times.
    function automatic logic [31:0] frac_weight(input int frac_bits, input int k);
        logic [31:0] w;
        w = 32'd1 << frac_bits;
        for (int i = 0; i < k; i++)
        begin
            w = w / 32'd10;
        end
        return w;
    endfunction

endpackage

// File: rtl/ascii_decimal_to_fixed_parser_core.sv
// ----------------------------------------------------------------------------
// ascii_decimal_to_fixed_parser_core
// Parses an ASCII decimal string, one character per transfer, into a signed
// fixed-point value with FRAC_BITS fraction bits.
// ----------------------------------------------------------------------------
// The final character is held in the input register, then the result and
// out_valid are registered as it advances. Throughput: one character per
// cycle; a final character waits in the input register only while a result
// is held with out_ready low.
// Reset: rst_n clears the parse state and both valid flags at once.
module ascii_decimal_to_fixed_parser_core #(
    parameter int FRAC_BITS = adfp_pkg::FRAC_BITS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic [7:0]                          character,
    input  logic                                last,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [adfp_pkg::VALUE_W-1:0] value,
    output logic                                overflow
);

    localparam int CntW = $clog2(adfp_pkg::WEIGHT_STEPS);
    localparam logic [CntW-1:0] CntMax = CntW'(adfp_pkg::WEIGHT_STEPS - 1);
    localparam logic signed [adfp_pkg::VALUE_W-1:0] OvfValue =
        -(64'sd1 <<< FRAC_BITS);

    // weight table, one entry per fraction digit position
    logic [FRAC_BITS-1:0] weight_tab [adfp_pkg::WEIGHT_STEPS];

    for (genvar k = 0; k < adfp_pkg::WEIGHT_STEPS; k++)
    begin : g_weight
        assign weight_tab[k] = FRAC_BITS'(adfp_pkg::frac_weight(FRAC_BITS, k));
    end

    // input stage
    logic       stg_valid_reg;
    logic [7:0] stg_char_reg;
    logic       stg_last_reg;
    logic       advance;

    // parse state
    adfp_pkg::phase_t                phase_reg, phase_next;
    logic                            negative_reg, negative_next;
    logic [adfp_pkg::INT_W-1:0]      int_reg, int_next;
    logic [FRAC_BITS-1:0]            frac_reg, frac_next;
    logic [CntW-1:0]                 cnt_reg, cnt_next;
    logic                            ovf_reg, ovf_next;

    // result
    logic                                out_valid_reg;
    logic signed [adfp_pkg::VALUE_W-1:0] value_reg, value_next;
    logic                                overflow_reg;

    logic                            dig_ok;
    logic [3:0]                      dig;
    logic [CntW-1:0]                 cnt_inc;
    logic [FRAC_BITS+3:0]            frac_prod;
    logic [adfp_pkg::VALUE_W-1:0]    mag;

    assign advance  = stg_valid_reg && (!stg_last_reg || !out_valid_reg || out_ready);
    assign in_ready = !stg_valid_reg || advance;

    assign dig_ok    = adfp_pkg::is_digit(stg_char_reg);
    assign dig       = stg_char_reg[3:0];
    assign cnt_inc   = (cnt_reg == CntMax) ? cnt_reg : cnt_reg + CntW'(1);
    assign frac_prod = dig * weight_tab[cnt_inc];

    always_comb
    begin
        phase_next    = phase_reg;
        negative_next = negative_reg;
        int_next      = int_reg;
        frac_next     = frac_reg;
        cnt_next      = cnt_reg;
        ovf_next      = ovf_reg;

        unique case (phase_reg)
            adfp_pkg::PH_SKIP,
            adfp_pkg::PH_INT:
            begin
                if (dig_ok)
                begin
                    if (int_reg > adfp_pkg::INT_LIMIT)
                    begin
                        ovf_next   = 1'b1;
                        phase_next = adfp_pkg::PH_DONE;
                    end
                    else
                    begin
                        int_next   = (int_reg << 3) + (int_reg << 1)
                                   + adfp_pkg::INT_W'(dig);
                        phase_next = adfp_pkg::PH_INT;
                    end
                end
                else if (stg_char_reg == adfp_pkg::CHAR_POINT)
                begin
                    phase_next = adfp_pkg::PH_FRAC;
                end
                else if (phase_reg == adfp_pkg::PH_SKIP
                         && adfp_pkg::is_blank(stg_char_reg))
                begin
                    phase_next = adfp_pkg::PH_SKIP;
                end
                else if (phase_reg == adfp_pkg::PH_SKIP
                         && (stg_char_reg == adfp_pkg::CHAR_MINUS
                             || stg_char_reg == adfp_pkg::CHAR_PLUS))
                begin
                    negative_next = (stg_char_reg == adfp_pkg::CHAR_MINUS);
                    phase_next    = adfp_pkg::PH_INT;
                end
                else
                begin
                    phase_next = adfp_pkg::PH_DONE;
                end
            end
            adfp_pkg::PH_FRAC:
            begin
                if (dig_ok)
                begin
                    cnt_next  = cnt_inc;
                    frac_next = frac_reg + FRAC_BITS'(frac_prod);
                end
                else
                begin
                    phase_next = adfp_pkg::PH_DONE;
                end
            end
            default:
            begin
                phase_next = adfp_pkg::PH_DONE;
            end
        endcase
    end

    // fraction stays below one, so the magnitude is a plain concatenation
    assign mag = adfp_pkg::VALUE_W'({int_next, frac_next});

    always_comb
    begin
        if (ovf_next)
        begin
            value_next = OvfValue;
        end
        else if (negative_next)
        begin
            value_next = -$signed(mag);
        end
        else
        begin
            value_next = $signed(mag);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stg_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
            phase_reg     <= adfp_pkg::PH_SKIP;
            negative_reg  <= 1'b0;
            int_reg       <= '0;
            frac_reg      <= '0;
            cnt_reg       <= '0;
            ovf_reg       <= 1'b0;
        end
        else
        begin
            if (in_ready)
            begin
                stg_valid_reg <= in_valid;
            end

            if (advance)
            begin
                if (stg_last_reg)
                begin
                    // string done: return to the reset state
                    phase_reg    <= adfp_pkg::PH_SKIP;
                    negative_reg <= 1'b0;
                    int_reg      <= '0;
                    frac_reg     <= '0;
                    cnt_reg      <= '0;
                    ovf_reg      <= 1'b0;
                end
                else
                begin
                    phase_reg    <= phase_next;
                    negative_reg <= negative_next;
                    int_reg      <= int_next;
                    frac_reg     <= frac_next;
                    cnt_reg      <= cnt_next;
                    ovf_reg      <= ovf_next;
                end
            end

            if (advance && stg_last_reg)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_ready && in_valid)
        begin
            stg_char_reg <= character;
            stg_last_reg <= last;
        end
        if (advance && stg_last_reg)
        begin
            value_reg    <= value_next;
            overflow_reg <= ovf_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign value     = value_reg;
    assign overflow  = overflow_reg;

`ifndef SYNTHESIS
    a_ovf_value: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && overflow_reg |-> value_reg == OvfValue)
        else $error("overflow result is not -1.0");

    a_ovf_done: assert property (@(posedge clk) disable iff (!rst_n)
        ovf_reg |-> phase_reg == adfp_pkg::PH_DONE)
        else $error("overflow flag set outside done phase");

    a_result_out: assert property (@(posedge clk) disable iff (!rst_n)
        advance && stg_last_reg |=> out_valid_reg)
        else $error("final character did not produce a result");

    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg <= CntMax)
        else $error("fraction digit count out of range");

    a_frac_phase: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != '0 |-> phase_reg == adfp_pkg::PH_FRAC
                          || phase_reg == adfp_pkg::PH_DONE)
        else $error("fraction digits counted outside fraction part");
`endif

endmodule

// File: dv/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for ascii_decimal_to_fixed_parser_core. Strings are sent
// one character per transfer; a cycle-free predictor parses the same stream
// and queues the fixed-point result that each final character must produce.
// A directed set covers blanks, signs, limits and stray bytes. Random strings
// follow, mostly well-formed numbers with random content and some noise,
// first with random gaps on both channels and then streaming back to back.
// ----------------------------------------------------------------------------
module testbench;

    localparam int FRAC_BITS      = adfp_pkg::FRAC_BITS_DEFAULT;
    localparam int WATCHDOG_LIMIT = 400;
    localparam int DRAIN_CYCLES   = 8;

    typedef struct packed {
        logic [63:0] value;
        logic        overflow;
    } fixed_result_t;

    logic                                clk       = 1'b0;
    logic                                rst_n     = 1'b0;
    logic                                in_valid  = 1'b0;
    logic                                in_ready;
    logic [7:0]                          character = 8'h00;
    logic                                last      = 1'b0;
    logic                                out_valid;
    logic                                out_ready = 1'b0;
    logic signed [adfp_pkg::VALUE_W-1:0] value;
    logic                                overflow;

    // Predictor state
    adfp_pkg::phase_t             cur_phase;
    logic                         is_neg;
    logic [adfp_pkg::INT_W-1:0]   int_acc;
    logic [28:0]                  frac_acc;
    logic [28:0]                  weight;
    logic                         int_ovf;

    fixed_result_t                fixed_result_q[$];
    logic [7:0]                   text_q[$];

    logic                         gaps_on = 1'b1;
    int                           mismatches = 0;
    int                           chars_sent = 0;
    int                           strings_sent = 0;
    int                           results_seen = 0;
    int                           overflows_seen = 0;
    int                           idle_cycles = 0;

    ascii_decimal_to_fixed_parser_core #(
        .FRAC_BITS(FRAC_BITS)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_ready(in_ready),
        .character(character),
        .last(last),
        .out_valid(out_valid),
        .out_ready(out_ready),
        .value(value),
        .overflow(overflow)
    );

    initial
    begin
        forever
        begin
            #1 clk = ~clk;
        end
    end

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    task automatic clear_parse();
        cur_phase = adfp_pkg::PH_SKIP;
        is_neg    = 1'b0;
        int_acc   = '0;
        frac_acc  = '0;
        weight    = 29'(64'd1 << FRAC_BITS);
        int_ovf   = 1'b0;
    endtask

    task automatic take_int_digit(input logic [3:0] d);
        // A digit that arrives past the limit ends parsing with overflow
        if (int_acc > adfp_pkg::INT_LIMIT)
        begin
            int_ovf   = 1'b1;
            cur_phase = adfp_pkg::PH_DONE;
        end
        else
        begin
            int_acc   = int_acc * 35'd10 + 35'(d);
            cur_phase = adfp_pkg::PH_INT;
        end
    endtask

    task automatic parse_char(input logic [7:0] c, input logic l);
        logic          is_dig;
        logic [3:0]    d;
        logic [63:0]   mag;
        fixed_result_t res;
        is_dig = (c >= adfp_pkg::CHAR_ZERO) && (c <= adfp_pkg::CHAR_NINE);
        d      = 4'(c - adfp_pkg::CHAR_ZERO);
        case (cur_phase)
            adfp_pkg::PH_SKIP:
            begin
                if ((c == adfp_pkg::CHAR_SPACE)
                    || ((c >= adfp_pkg::CHAR_TAB) && (c <= adfp_pkg::CHAR_CR)))
                begin
                    cur_phase = adfp_pkg::PH_SKIP;
                end
                else if ((c == adfp_pkg::CHAR_MINUS) || (c == adfp_pkg::CHAR_PLUS))
                begin
                    is_neg    = (c == adfp_pkg::CHAR_MINUS);
                    cur_phase = adfp_pkg::PH_INT;
                end
                else if (is_dig)
                    take_int_digit(d);
                else if (c == adfp_pkg::CHAR_POINT)
                    cur_phase = adfp_pkg::PH_FRAC;
                else
                    cur_phase = adfp_pkg::PH_DONE;
            end
            adfp_pkg::PH_INT:
            begin
                if (is_dig)
                    take_int_digit(d);
                else if (c == adfp_pkg::CHAR_POINT)
                    cur_phase = adfp_pkg::PH_FRAC;
                else
                    cur_phase = adfp_pkg::PH_DONE;
            end
            adfp_pkg::PH_FRAC:
            begin
                if (is_dig)
                begin
                    weight   = weight / 29'd10;
                    frac_acc = frac_acc + d * weight;
                end
                else
                    cur_phase = adfp_pkg::PH_DONE;
            end
            default:
                cur_phase = adfp_pkg::PH_DONE;
        endcase
        if (l)
        begin
            if (int_ovf)
            begin
                res.value    = 64'd0 - (64'd1 << FRAC_BITS);
                res.overflow = 1'b1;
            end
            else
            begin
                mag          = (64'(int_acc) << FRAC_BITS) + 64'(frac_acc);
                res.value    = is_neg ? (64'd0 - mag) : mag;
                res.overflow = 1'b0;
            end
            fixed_result_q.push_back(res);
            strings_sent++;
            clear_parse();
        end
    endtask

    // ------------------------------------------------------------------
    // Input side
    // ------------------------------------------------------------------
    task automatic send_char(input logic [7:0] c, input logic l);
        int gap;
        gap = gaps_on ? $urandom_range(0, 7) : 0;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid  <= 1'b1;
        character <= c;
        last      <= l;
        do
            @(posedge clk);
        while (!(in_valid && in_ready));
        parse_char(c, l);
        chars_sent++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
        begin
            text_q.push_back(s[i]);
        end
    endtask

    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++)
        begin
            send_char(text_q[i], i == text_q.size() - 1);
        end
        text_q.delete();
    endtask

    task automatic send_string(input string s);
        push_text(s);
        send_text();
    endtask

    function automatic logic [7:0] rand_digit();
        return adfp_pkg::CHAR_ZERO + 8'($urandom_range(0, 9));
    endfunction

    // ------------------------------------------------------------------
    // Output side: random stalls, check each transfer against the queue
    // ------------------------------------------------------------------
    initial
    begin
        int            gap;
        fixed_result_t exp_res;
        wait (rst_n);
        forever
        begin
            gap = gaps_on ? $urandom_range(0, 7) : 0;
            if (gap > 0)
            begin
                out_ready <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            out_ready <= 1'b1;
            do
                @(posedge clk);
            while (!(out_valid && out_ready));
            results_seen++;
            if (overflow)
                overflows_seen++;
            if (fixed_result_q.size() == 0)
            begin
                $display("%0t: unexpected result value %h overflow %b",
                         $time, value, overflow);
                mismatches++;
            end
            else
            begin
                exp_res = fixed_result_q.pop_front();
                if (value !== exp_res.value)
                begin
                    $display("%0t: value expected %h actual %h",
                             $time, exp_res.value, value);
                    mismatches++;
                end
                if (overflow !== exp_res.overflow)
                begin
                    $display("%0t: overflow expected %b actual %b",
                             $time, exp_res.overflow, overflow);
                    mismatches++;
                end
            end
        end
    end

    // Abort when neither channel moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready))
            idle_cycles <= 0;
        else
        begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("%0t: no transfer for %0d cycles", $time, idle_cycles);
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_basic_numbers();
        send_string("0");
        send_string("+123.5");
        send_string("-42.75");
        send_string("007");
        send_string("1.");
    endtask

    task automatic test_blanks();
        text_q.push_back(adfp_pkg::CHAR_SPACE);
        for (int c = adfp_pkg::CHAR_TAB; c <= adfp_pkg::CHAR_CR; c++)
        begin
            text_q.push_back(8'(c));
        end
        push_text("-3");
        send_text();
    endtask

    task automatic test_sign_rules();
        send_string("+-1");
        send_string("- 1");
        send_string("-0.0");
        send_string("-.5");
        send_string(".25");
        send_string("-");
    endtask

    task automatic test_int_limit();
        send_string("21474836479.99999");
        send_string("-2147483648");
        send_string("21474836480");
        send_string("-99999999999");
    endtask

    task automatic test_fraction_weight();
        // Weight runs out after eight digits; the rest add nothing
        send_string("0.123456789012");
    endtask

    task automatic test_stray_bytes();
        text_q.push_back(8'h00);
        push_text("5");
        send_text();
        push_text("1");
        text_q.push_back(8'h80);
        push_text("2");
        send_text();
        text_q.push_back(8'hFF);
        send_text();
        send_string("3x4");
        send_string("4 5");
    endtask

    task automatic build_number();
        int n_int;
        int n_frac;
        for (int i = $urandom_range(0, 2); i > 0; i--)
        begin
            if ($urandom_range(0, 1))
                text_q.push_back(adfp_pkg::CHAR_SPACE);
            else
                text_q.push_back(8'($urandom_range(adfp_pkg::CHAR_TAB, adfp_pkg::CHAR_CR)));
        end
        case ($urandom_range(0, 3))
            0: text_q.push_back(adfp_pkg::CHAR_PLUS);
            1: text_q.push_back(adfp_pkg::CHAR_MINUS);
            default: ;
        endcase
        // Long integer parts now and then, to reach the overflow limit
        n_int = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 6);
        for (int i = 0; i < n_int; i++)
        begin
            text_q.push_back(($urandom_range(0, 3) == 0) ? adfp_pkg::CHAR_NINE
                                                           : rand_digit());
        end
        if ($urandom_range(0, 9) < 7)
        begin
            text_q.push_back(adfp_pkg::CHAR_POINT);
            n_frac = ($urandom_range(0, 5) == 0) ? $urandom_range(9, 12) : $urandom_range(0, 5);
            for (int i = 0; i < n_frac; i++)
            begin
                text_q.push_back(rand_digit());
            end
        end
        if ($urandom_range(0, 4) == 0)
        begin
            for (int i = $urandom_range(1, 3); i > 0; i--)
            begin
                text_q.push_back(8'($urandom_range(0, 255)));
            end
        end
        if (text_q.size() == 0)
            text_q.push_back(rand_digit());
    endtask

    task automatic send_random_strings(input int n_chars);
        int stop_at;
        int kind;
        stop_at = chars_sent + n_chars;
        while (chars_sent < stop_at)
        begin
            kind = $urandom_range(0, 9);
            if (kind == 0)
            begin
                for (int i = $urandom_range(1, 5); i > 0; i--)
                begin
                    text_q.push_back(8'($urandom_range(0, 255)));
                end
            end
            else
            begin
                build_number();
                // Break a well-formed string at a random position
                if (kind == 1)
                    text_q[$urandom_range(0, text_q.size() - 1)] = 8'($urandom_range(0, 255));
            end
            send_text();
        end
    endtask

    task automatic test_random_bursty();
        gaps_on = 1'b1;
        send_random_strings(300);
    endtask

    task automatic test_random_streaming();
        gaps_on = 1'b0;
        send_random_strings(180);
    endtask

    initial
    begin
        clear_parse();
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_numbers();
        test_blanks();
        test_sign_rules();
        test_int_limit();
        test_fraction_weight();
        test_stray_bytes();
        test_random_bursty();
        test_random_streaming();
        in_valid <= 1'b0;
        while (fixed_result_q.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Sent %0d characters in %0d strings; checked %0d results.",
                 chars_sent, strings_sent, results_seen);
        $display("Overflow results seen: %0d; mismatches: %0d.", overflows_seen, mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// File: files.f
rtl/adfp_pkg.sv
rtl/ascii_decimal_to_fixed_parser_core.sv
dv/testbench.sv
